/* rtl/lavm_pkg.sv */
// Shared constants, the side-band type and the rounding helpers of the look-at view matrix unit.
// No dependencies; used by lavm_unitize and look_at_view_matrix_unit.
package lavm_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int UNIT_W     = 18;
    localparam int SHIFT_W    = 40;
    localparam int NORM_BITS  = 30;
    localparam int VEC_W      = 52;
    localparam int LEN_W      = 7;
    localparam int SUM_W      = 2 * NORM_BITS + 2;
    localparam int SQ_STEPS   = SUM_W / 2;
    localparam int R_W        = NORM_BITS + 1;
    localparam int REM_W      = NORM_BITS + 4;
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int NUM_W      = NORM_BITS + FRAC_BITS + 1;
    localparam int PU_W       = 2 * UNIT_W;
    localparam int PE_W       = UNIT_W + IN_W;
    localparam int DOT_W      = PE_W + 2;
    localparam int IN_DATA_W  = 9 * IN_W;
    localparam int OUT_FLD_W  = 9 * UNIT_W + 3 * SHIFT_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Item data that rides alongside a vector through a normalization pipe.
    typedef struct packed {
        logic [2:0][IN_W-1:0]   eye;
        logic [2:0][IN_W-1:0]   up;
        logic [2:0][UNIT_W-1:0] fwd;
        logic                   ok;
    } side_t;

    // Shift right by FRAC_BITS, rounding half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [UNIT_W-1:0] sat_unit(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (UNIT_W - 1)) - 64'sd1;
        if (v > hi) begin
            return UNIT_W'(hi);
        end else if (v < -hi - 64'sd1) begin
            return UNIT_W'(-hi - 64'sd1);
        end
        return UNIT_W'(v);
    endfunction

    function automatic logic [SHIFT_W-1:0] sat_shift(input logic signed [63:0] v);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (SHIFT_W - 1)) - 64'sd1;
        if (v > hi) begin
            return SHIFT_W'(hi);
        end else if (v < -hi - 64'sd1) begin
            return SHIFT_W'(-hi - 64'sd1);
        end
        return SHIFT_W'(v);
    endfunction

endpackage

/* rtl/lavm_unitize.sv */
// Pipelined vector normalization: magnitude scaling, sum of squares, bit-per-stage square root
// and bit-per-stage division. Depends on lavm_pkg.
module lavm_unitize
    import lavm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2:0][VEC_W-1:0]  vec_in,
    input  side_t                  side_in,
    output logic                   out_valid,
    output logic                   out_ok,
    output logic [2:0][UNIT_W-1:0] unit_out,
    output side_t                  side_out
);

    typedef struct packed {
        logic [2:0][NORM_BITS-1:0] w;
        logic [2:0]                neg;
        logic                      zero;
        side_t                     side;
    } carry_t;

    // Stage A: magnitudes and their OR (same bit length as the largest).
    logic                  a_valid_reg;
    logic [2:0][VEC_W-1:0] a_mag_reg;
    logic [2:0]            a_neg_reg;
    logic [VEC_W-1:0]      a_or_reg;
    side_t                 a_side_reg;
    logic [2:0][VEC_W-1:0] a_mag_next;

    // Stage B: bit length.
    logic                  b_valid_reg;
    logic [2:0][VEC_W-1:0] b_mag_reg;
    logic [2:0]            b_neg_reg;
    logic [LEN_W-1:0]      b_len_reg;
    side_t                 b_side_reg;
    logic [LEN_W-1:0]      b_len_next;

    // Stage C: scaled components; stage D: squares.
    logic                       c_valid_reg;
    carry_t                     c_carry_reg;
    carry_t                     c_carry_next;
    logic                       d_valid_reg;
    carry_t                     d_carry_reg;
    logic [2:0][2*NORM_BITS-1:0] d_sq_reg;

    // Square root stages.
    logic             sq_valid_reg [SQ_STEPS+1];
    logic [SUM_W-1:0] sq_x_reg     [SQ_STEPS+1];
    logic [REM_W-1:0] sq_rem_reg   [SQ_STEPS+1];
    logic [R_W-1:0]   sq_root_reg  [SQ_STEPS+1];
    carry_t           sq_carry_reg [SQ_STEPS+1];
    logic [SUM_W-1:0] sq_x_next    [SQ_STEPS+1];
    logic [REM_W-1:0] sq_rem_next  [SQ_STEPS+1];
    logic [R_W-1:0]   sq_root_next [SQ_STEPS+1];

    // Division stages, three quotients sharing one divisor.
    logic                dv_valid_reg [Q_W+1];
    logic [R_W-1:0]      dv_r_reg     [Q_W+1];
    logic [2:0][R_W-1:0] dv_rem_reg   [Q_W+1];
    logic [2:0][Q_W-1:0] dv_low_reg   [Q_W+1];
    logic [2:0][Q_W-1:0] dv_q_reg     [Q_W+1];
    carry_t              dv_carry_reg [Q_W+1];
    logic [2:0][R_W-1:0] dv_rem_next  [Q_W+1];
    logic [2:0][Q_W-1:0] dv_low_next  [Q_W+1];
    logic [2:0][Q_W-1:0] dv_q_next    [Q_W+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_mag_next[i] = vec_in[i][VEC_W-1] ? VEC_W'(-vec_in[i]) : vec_in[i];
        end
    end

    // Bit length by a six-step binary search.
    always_comb begin
        logic [63:0]      x;
        logic [LEN_W-1:0] n;
        x = 64'(a_or_reg);
        n = '0;
        for (int k = 5; k >= 0; k--) begin
            if ((x >> (1 << k)) != 64'd0) begin
                n = n + LEN_W'(1 << k);
                x = x >> (1 << k);
            end
        end
        b_len_next = n + LEN_W'(x[0]);
    end

    always_comb begin
        c_carry_next.neg  = b_neg_reg;
        c_carry_next.zero = (b_len_reg == '0);
        c_carry_next.side = b_side_reg;
        for (int i = 0; i < 3; i++) begin
            if (b_len_reg > LEN_W'(NORM_BITS)) begin
                c_carry_next.w[i] = NORM_BITS'(b_mag_reg[i] >> (b_len_reg - LEN_W'(NORM_BITS)));
            end else begin
                c_carry_next.w[i] = NORM_BITS'(b_mag_reg[i] << (LEN_W'(NORM_BITS) - b_len_reg));
            end
        end
    end

    // One result bit per stage of the square root.
    always_comb begin
        logic [REM_W-1:0] rem_t;
        logic [REM_W-1:0] trial;
        sq_x_next[0]    = SUM_W'(d_sq_reg[0]) + SUM_W'(d_sq_reg[1]) + SUM_W'(d_sq_reg[2]);
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        for (int j = 1; j <= SQ_STEPS; j++) begin
            rem_t        = {sq_rem_reg[j-1][REM_W-3:0], sq_x_reg[j-1][SUM_W-1 -: 2]};
            trial        = REM_W'({sq_root_reg[j-1], 2'b01});
            sq_x_next[j] = sq_x_reg[j-1] << 2;
            if (rem_t >= trial) begin
                sq_rem_next[j]  = rem_t - trial;
                sq_root_next[j] = {sq_root_reg[j-1][R_W-2:0], 1'b1};
            end else begin
                sq_rem_next[j]  = rem_t;
                sq_root_next[j] = {sq_root_reg[j-1][R_W-2:0], 1'b0};
            end
        end
    end

    // Restoring division, one quotient bit per stage; numerator is w * 2^F + r / 2.
    always_comb begin
        logic [NUM_W-1:0] num;
        logic [R_W:0]     rem_t;
        for (int i = 0; i < 3; i++) begin
            num = (NUM_W'(sq_carry_reg[SQ_STEPS].w[i]) << FRAC_BITS)
                + NUM_W'(sq_root_reg[SQ_STEPS] >> 1);
            dv_rem_next[0][i] = R_W'(num >> Q_W);
            dv_low_next[0][i] = num[Q_W-1:0];
            dv_q_next[0][i]   = '0;
        end
        for (int k = 1; k <= Q_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                rem_t = {dv_rem_reg[k-1][i], dv_low_reg[k-1][i][Q_W-1]};
                dv_low_next[k][i] = dv_low_reg[k-1][i] << 1;
                if (rem_t >= {1'b0, dv_r_reg[k-1]}) begin
                    dv_rem_next[k][i] = R_W'(rem_t - {1'b0, dv_r_reg[k-1]});
                    dv_q_next[k][i]   = {dv_q_reg[k-1][i][Q_W-2:0], 1'b1};
                end else begin
                    dv_rem_next[k][i] = R_W'(rem_t);
                    dv_q_next[k][i]   = {dv_q_reg[k-1][i][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            for (int j = 0; j <= SQ_STEPS; j++) begin
                sq_valid_reg[j] <= 1'b0;
            end
            for (int k = 0; k <= Q_W; k++) begin
                dv_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            sq_valid_reg[0] <= d_valid_reg;
            for (int j = 1; j <= SQ_STEPS; j++) begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
            for (int k = 1; k <= Q_W; k++) begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg  <= a_mag_next;
            a_or_reg   <= a_mag_next[0] | a_mag_next[1] | a_mag_next[2];
            a_side_reg <= side_in;
            for (int i = 0; i < 3; i++) begin
                a_neg_reg[i] <= vec_in[i][VEC_W-1];
            end
            b_mag_reg   <= a_mag_reg;
            b_neg_reg   <= a_neg_reg;
            b_len_reg   <= b_len_next;
            b_side_reg  <= a_side_reg;
            c_carry_reg <= c_carry_next;
            d_carry_reg <= c_carry_reg;
            for (int i = 0; i < 3; i++) begin
                d_sq_reg[i] <= (2*NORM_BITS)'(c_carry_reg.w[i]) * (2*NORM_BITS)'(c_carry_reg.w[i]);
            end
            sq_carry_reg[0] <= d_carry_reg;
            for (int j = 0; j <= SQ_STEPS; j++) begin
                sq_x_reg[j]    <= sq_x_next[j];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end
            for (int j = 1; j <= SQ_STEPS; j++) begin
                sq_carry_reg[j] <= sq_carry_reg[j-1];
            end
            dv_r_reg[0]     <= sq_root_reg[SQ_STEPS];
            dv_carry_reg[0] <= sq_carry_reg[SQ_STEPS];
            for (int k = 1; k <= Q_W; k++) begin
                dv_r_reg[k]     <= dv_r_reg[k-1];
                dv_carry_reg[k] <= dv_carry_reg[k-1];
            end
            for (int k = 0; k <= Q_W; k++) begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_low_reg[k] <= dv_low_next[k];
                dv_q_reg[k]   <= dv_q_next[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unit_out[i] = sat_unit(dv_carry_reg[Q_W].neg[i] ? -$signed(64'(dv_q_reg[Q_W][i]))
                                                          : $signed(64'(dv_q_reg[Q_W][i])));
        end
    end

    assign out_valid = dv_valid_reg[Q_W];
    assign out_ok    = !dv_carry_reg[Q_W].zero;
    assign side_out  = dv_carry_reg[Q_W].side;

endmodule

/* rtl/look_at_view_matrix_unit.sv */
// Top level of the look-at view matrix unit: forward and side normalization pipes,
// cross products, true up and translation dot products. Depends on lavm_pkg, lavm_unitize.
//
//  channel  | direction | word contents
//  ---------+-----------+------------------------------------------------------------
//  s_       | in        | eye, target and up vectors, nine signed Q16.16 fields
//  m_       | out       | side, true up, negated forward (Q2.16), three translations
//
// The unit takes one word per cycle while the output channel does not stall. A word passes
// 117 register stages before its result is offered on the output. The depth is set by the
// two normalization pipes of 54 stages each, with one square-root stage per result bit and
// one division stage per quotient bit. Reset (aresetn low at a clock edge) empties the
// pipeline. A stall on the output channel holds every stage, so nothing is lost or repeated;
// the input side keeps accepting words as long as the output register is empty or being taken.
module look_at_view_matrix_unit
    import lavm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // side_x, side_y, side_z, trueup_x, trueup_y, trueup_z, negfwd_x, negfwd_y, negfwd_z,
    // shift_side, shift_up, shift_fwd, then zero padding
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    // The whole pipeline moves together whenever the output register can take a word.
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // Input stage: forward difference target minus eye, exact in 33 bits.
    logic                  v0_reg;
    logic [2:0][VEC_W-1:0] d0_reg;
    side_t                 side0_reg;
    side_t                 side0_next;
    logic [2:0][VEC_W-1:0] d0_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            side0_next.eye[i] = s_tdata[i*IN_W +: IN_W];
            side0_next.up[i]  = s_tdata[(6+i)*IN_W +: IN_W];
            d0_next[i] = VEC_W'($signed(s_tdata[(3+i)*IN_W +: IN_W]))
                       - VEC_W'($signed(s_tdata[i*IN_W +: IN_W]));
        end
        side0_next.fwd = '0;
        side0_next.ok  = 1'b1;
    end

    // Forward direction.
    logic                   u1_valid;
    logic                   u1_ok;
    logic [2:0][UNIT_W-1:0] f_unit;
    side_t                  u1_side;

    lavm_unitize u_fwd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v0_reg),
        .vec_in   (d0_reg),
        .side_in  (side0_reg),
        .out_valid(u1_valid),
        .out_ok   (u1_ok),
        .unit_out (f_unit),
        .side_out (u1_side)
    );

    // Cross of forward and up: products, then differences.
    logic                        x1_valid_reg;
    side_t                       x1_side_reg;
    logic signed [PE_W-1:0]      x1_pr_reg [6];
    logic                        x2_valid_reg;
    side_t                       x2_side_reg;
    logic [2:0][VEC_W-1:0]       x2_c_reg;
    side_t                       x1_side_next;

    always_comb begin
        x1_side_next     = u1_side;
        x1_side_next.fwd = f_unit;
        x1_side_next.ok  = u1_ok;
    end

    // Side direction.
    logic                   u2_valid;
    logic                   u2_ok;
    logic [2:0][UNIT_W-1:0] s_unit;
    side_t                  u2_side;

    lavm_unitize u_side (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (x2_valid_reg),
        .vec_in   (x2_c_reg),
        .side_in  (x2_side_reg),
        .out_valid(u2_valid),
        .out_ok   (u2_ok),
        .unit_out (s_unit),
        .side_out (u2_side)
    );

    // Back end: true up and translations.
    logic                   p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg;
    logic                   p1_ok_reg, p2_ok_reg, p3_ok_reg, p4_ok_reg, p5_ok_reg;
    logic [2:0][UNIT_W-1:0] p1_s_reg, p2_s_reg, p3_s_reg, p4_s_reg, p5_s_reg;
    logic [2:0][UNIT_W-1:0] p1_f_reg, p2_f_reg, p3_f_reg, p4_f_reg, p5_f_reg;
    logic [2:0][IN_W-1:0]   p1_eye_reg, p2_eye_reg, p3_eye_reg;
    logic signed [PU_W-1:0] p1_uf_reg [6];
    logic signed [PE_W-1:0] p1_se_reg [3];
    logic signed [PE_W-1:0] p1_fe_reg [3];
    logic signed [PU_W-1:0] p2_uraw_reg [3];
    logic signed [DOT_W-1:0] p2_ds_reg, p2_df_reg;
    logic [2:0][UNIT_W-1:0] p3_u_reg, p4_u_reg, p5_u_reg;
    logic [SHIFT_W-1:0]     p3_ts_reg, p4_ts_reg, p5_ts_reg;
    logic [SHIFT_W-1:0]     p3_tf_reg, p4_tf_reg, p5_tf_reg;
    logic signed [PE_W-1:0] p4_ue_reg [3];
    logic signed [DOT_W-1:0] p5_du_reg;
    logic [2:0][UNIT_W-1:0] p3_u_next;

    always_comb begin
        logic signed [63:0] r;
        for (int i = 0; i < 3; i++) begin
            r = round_shift(64'(p2_uraw_reg[i]));
            if (r > (64'sd1 <<< FRAC_BITS)) begin
                r = 64'sd1 <<< FRAC_BITS;
            end else if (r < -(64'sd1 <<< FRAC_BITS)) begin
                r = -(64'sd1 <<< FRAC_BITS);
            end
            p3_u_next[i] = sat_unit(r);
        end
    end

    // Result word; a degenerate view gives all zeros.
    always_comb begin
        m_tdata_next = '0;
        if (p5_ok_reg) begin
            for (int i = 0; i < 3; i++) begin
                m_tdata_next[i*UNIT_W +: UNIT_W]     = p5_s_reg[i];
                m_tdata_next[(3+i)*UNIT_W +: UNIT_W] = p5_u_reg[i];
                m_tdata_next[(6+i)*UNIT_W +: UNIT_W] = sat_unit(-$signed(64'($signed(p5_f_reg[i]))));
            end
            m_tdata_next[9*UNIT_W +: SHIFT_W]             = p5_ts_reg;
            m_tdata_next[9*UNIT_W + SHIFT_W +: SHIFT_W]   = sat_shift(-round_shift(64'(p5_du_reg)));
            m_tdata_next[9*UNIT_W + 2*SHIFT_W +: SHIFT_W] = p5_tf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            x1_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v0_reg       <= s_tvalid;
            x1_valid_reg <= u1_valid;
            x2_valid_reg <= x1_valid_reg;
            p1_valid_reg <= u2_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
            m_tvalid_reg <= p5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg    <= d0_next;
            side0_reg <= side0_next;

            x1_side_reg  <= x1_side_next;
            x1_pr_reg[0] <= $signed(f_unit[1]) * $signed(u1_side.up[2]);
            x1_pr_reg[1] <= $signed(f_unit[2]) * $signed(u1_side.up[1]);
            x1_pr_reg[2] <= $signed(f_unit[2]) * $signed(u1_side.up[0]);
            x1_pr_reg[3] <= $signed(f_unit[0]) * $signed(u1_side.up[2]);
            x1_pr_reg[4] <= $signed(f_unit[0]) * $signed(u1_side.up[1]);
            x1_pr_reg[5] <= $signed(f_unit[1]) * $signed(u1_side.up[0]);

            x2_side_reg <= x1_side_reg;
            for (int i = 0; i < 3; i++) begin
                x2_c_reg[i] <= VEC_W'(x1_pr_reg[2*i]) - VEC_W'(x1_pr_reg[2*i+1]);
            end

            p1_ok_reg    <= u2_ok && u2_side.ok;
            p1_s_reg     <= s_unit;
            p1_f_reg     <= u2_side.fwd;
            p1_eye_reg   <= u2_side.eye;
            p1_uf_reg[0] <= $signed(s_unit[1]) * $signed(u2_side.fwd[2]);
            p1_uf_reg[1] <= $signed(s_unit[2]) * $signed(u2_side.fwd[1]);
            p1_uf_reg[2] <= $signed(s_unit[2]) * $signed(u2_side.fwd[0]);
            p1_uf_reg[3] <= $signed(s_unit[0]) * $signed(u2_side.fwd[2]);
            p1_uf_reg[4] <= $signed(s_unit[0]) * $signed(u2_side.fwd[1]);
            p1_uf_reg[5] <= $signed(s_unit[1]) * $signed(u2_side.fwd[0]);
            for (int i = 0; i < 3; i++) begin
                p1_se_reg[i] <= $signed(s_unit[i]) * $signed(u2_side.eye[i]);
                p1_fe_reg[i] <= $signed(u2_side.fwd[i]) * $signed(u2_side.eye[i]);
            end

            p2_ok_reg  <= p1_ok_reg;
            p2_s_reg   <= p1_s_reg;
            p2_f_reg   <= p1_f_reg;
            p2_eye_reg <= p1_eye_reg;
            for (int i = 0; i < 3; i++) begin
                p2_uraw_reg[i] <= p1_uf_reg[2*i] - p1_uf_reg[2*i+1];
            end
            p2_ds_reg <= DOT_W'(p1_se_reg[0]) + DOT_W'(p1_se_reg[1]) + DOT_W'(p1_se_reg[2]);
            p2_df_reg <= DOT_W'(p1_fe_reg[0]) + DOT_W'(p1_fe_reg[1]) + DOT_W'(p1_fe_reg[2]);

            p3_ok_reg  <= p2_ok_reg;
            p3_s_reg   <= p2_s_reg;
            p3_f_reg   <= p2_f_reg;
            p3_eye_reg <= p2_eye_reg;
            p3_u_reg   <= p3_u_next;
            p3_ts_reg  <= sat_shift(-round_shift(64'(p2_ds_reg)));
            p3_tf_reg  <= sat_shift(round_shift(64'(p2_df_reg)));

            p4_ok_reg <= p3_ok_reg;
            p4_s_reg  <= p3_s_reg;
            p4_f_reg  <= p3_f_reg;
            p4_u_reg  <= p3_u_reg;
            p4_ts_reg <= p3_ts_reg;
            p4_tf_reg <= p3_tf_reg;
            for (int i = 0; i < 3; i++) begin
                p4_ue_reg[i] <= $signed(p3_u_reg[i]) * $signed(p3_eye_reg[i]);
            end

            p5_ok_reg <= p4_ok_reg;
            p5_s_reg  <= p4_s_reg;
            p5_f_reg  <= p4_f_reg;
            p5_u_reg  <= p4_u_reg;
            p5_ts_reg <= p4_ts_reg;
            p5_tf_reg <= p4_tf_reg;
            p5_du_reg <= DOT_W'(p4_ue_reg[0]) + DOT_W'(p4_ue_reg[1]) + DOT_W'(p4_ue_reg[2]);

            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
